FILE: hw/rtl/mhal_pkg.sv
// shared types and constants for the mail header address locator
package mhal_pkg;

  // payload widths
  localparam int CHAR_W  = 8;
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  // character codes that steer the scan
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  // one located-address word
  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_pos;
    logic [LEN_W-1:0]   addr_length;
    logic               overflow;
  } result_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: hw/rtl/mhal_in_if.sv
// character channel: header bytes and end marker
interface mhal_in_if
  import mhal_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_marker;

  modport source (output valid, output char_code, output end_marker, input ready);
  modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

FILE: hw/rtl/mhal_out_if.sv
// result channel: located address words
interface mhal_out_if
  import mhal_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] start_pos;
  logic [LEN_W-1:0]   addr_length;
  logic               overflow;

  modport source (output valid, output found, output start_pos, output addr_length,
                  output overflow, input ready);
  modport sink   (input valid, input found, input start_pos, input addr_length,
                  input overflow, output ready);
endinterface

FILE: hw/rtl/mail_header_address_locator_unit.sv
// mail header address locator: scans header bytes, reports the first <...> address, else the first plain token
//
//   channel  | dir | payload                                   | word per
//   ---------+-----+-------------------------------------------+-----------------
//   chars    | in  | char_code[7:0], end_marker                | header byte/end
//   result   | out | found, start_pos[9:0], addr_length[10:0], | end marker
//            |     | overflow                                  |
//
// one word is taken per cycle; a byte updates the scan state in the cycle it
// is taken, an end marker loads the result register and clears the scan state
// in that same cycle, so the next header can start on the following cycle.
// chars stalls only while a result sits unread in the output register.
// rst (synchronous) clears the scan state and empties the output register.
module mail_header_address_locator_unit
  import mhal_pkg::*;
#(
  parameter int MAX_LEN  = 1024,
  parameter int MAX_NEST = 255
) (
  input  logic        clk,
  input  logic        rst,
  mhal_in_if.sink     chars,
  mhal_out_if.source  result
);

  // position counts up to MAX_LEN itself
  localparam int PW = $clog2(MAX_LEN + 1);
  // comment depth saturates at MAX_NEST
  localparam int DW = $clog2(MAX_NEST + 1);
  // working width for the result arithmetic before truncation to the port
  localparam int RW = (PW > LEN_W) ? PW : LEN_W;

  // scan state
  logic [PW-1:0] position, position_next;
  logic          escape_pending, escape_pending_next;
  logic          in_angle, in_angle_next;
  logic          in_quote, in_quote_next;
  logic [DW-1:0] comment_depth, comment_depth_next;
  logic [PW-1:0] angle_start, angle_start_next;
  logic          angle_start_valid, angle_start_valid_next;
  logic [PW-1:0] angle_len, angle_len_next;
  logic          angle_len_valid, angle_len_valid_next;
  logic [PW-1:0] plain_start, plain_start_next;
  logic          plain_start_valid, plain_start_valid_next;
  logic [PW-1:0] plain_len, plain_len_next;
  logic          plain_len_valid, plain_len_valid_next;
  logic          plain_first_is_quote, plain_first_is_quote_next;
  logic          plain_last_is_quote, plain_last_is_quote_next;
  logic          prev_char_is_quote, prev_char_is_quote_next;
  logic          overflowed, overflowed_next;

  // output register
  logic    out_valid;
  result_t out_word;
  result_t res;

  logic          take;
  logic          take_char;
  logic          take_end;
  logic [CHAR_W-1:0] c;

  // result arithmetic
  logic [PW-1:0] plain_len_eff;
  logic          last_q;
  logic          strip;
  logic [RW-1:0] start_wide;
  logic [RW-1:0] len_wide;

  // a new word may enter whenever the output register is empty or draining
  assign chars.ready = !out_valid || result.ready;
  assign take        = chars.valid && chars.ready;
  assign take_char   = take && !chars.end_marker;
  assign take_end    = take && chars.end_marker;
  assign c           = chars.char_code;

  // per-byte scan update, priority follows the escape/angle/comment/quote order
  always_comb begin
    position_next             = position;
    escape_pending_next       = escape_pending;
    in_angle_next             = in_angle;
    in_quote_next             = in_quote;
    comment_depth_next        = comment_depth;
    angle_start_next          = angle_start;
    angle_start_valid_next    = angle_start_valid;
    angle_len_next            = angle_len;
    angle_len_valid_next      = angle_len_valid;
    plain_start_next          = plain_start;
    plain_start_valid_next    = plain_start_valid;
    plain_len_next            = plain_len;
    plain_len_valid_next      = plain_len_valid;
    plain_first_is_quote_next = plain_first_is_quote;
    plain_last_is_quote_next  = plain_last_is_quote;
    prev_char_is_quote_next   = prev_char_is_quote;
    overflowed_next           = overflowed;

    if (take_char) begin
      if (position >= PW'(MAX_LEN)) begin
        // bytes past the limit only mark the overflow
        overflowed_next = 1'b1;
      end else begin
        priority if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (c == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (in_angle) begin
          if (!angle_start_valid) begin
            angle_start_next       = position;
            angle_start_valid_next = 1'b1;
          end
          if (c == CH_GT) begin
            in_angle_next = 1'b0;
            if (!angle_len_valid) begin
              // start is this byte when it was not yet set, giving zero length
              angle_len_next       = angle_start_valid ? (position - angle_start) : '0;
              angle_len_valid_next = 1'b1;
            end
          end
        end else if (comment_depth != '0) begin
          if (c == CH_LPAR) begin
            if (comment_depth < DW'(MAX_NEST)) begin
              comment_depth_next = comment_depth + DW'(1);
            end
          end else if (c == CH_RPAR) begin
            comment_depth_next = comment_depth - DW'(1);
          end
        end else if (in_quote) begin
          if (c == CH_DQUOTE) begin
            in_quote_next = 1'b0;
          end
        end else if (c == CH_LT) begin
          in_angle_next = 1'b1;
        end else if (c == CH_LPAR) begin
          comment_depth_next = DW'(1);
        end else if (c == CH_DQUOTE) begin
          in_quote_next = 1'b1;
          if (!plain_start_valid) begin
            plain_start_next          = position;
            plain_start_valid_next    = 1'b1;
            plain_first_is_quote_next = 1'b1;
          end
        end else if (is_space(c)) begin
          // whitespace closes the first plain token
          if (plain_start_valid && !plain_len_valid) begin
            plain_len_next           = position - plain_start;
            plain_len_valid_next     = 1'b1;
            plain_last_is_quote_next = prev_char_is_quote;
          end
        end else begin
          if (!plain_start_valid) begin
            plain_start_next          = position;
            plain_start_valid_next    = 1'b1;
            plain_first_is_quote_next = 1'b0;
          end
        end
        prev_char_is_quote_next = (c == CH_DQUOTE);
        position_next           = position + PW'(1);
      end
    end
  end

  // end-marker result from the current scan state
  assign plain_len_eff = plain_len_valid ? plain_len : (position - plain_start);
  assign last_q        = plain_len_valid ? plain_last_is_quote : prev_char_is_quote;
  assign strip         = (plain_len_eff > PW'(1)) && plain_first_is_quote && last_q;

  always_comb begin
    res        = '0;
    start_wide = '0;
    len_wide   = '0;
    if (!overflowed) begin
      priority if (angle_start_valid && angle_len_valid) begin
        start_wide = RW'(angle_start);
        len_wide   = RW'(angle_len);
        res.found  = 1'b1;
      end else if (plain_start_valid) begin
        // drop the surrounding double quotes of a quoted token
        start_wide = RW'(plain_start) + (strip ? RW'(1) : '0);
        len_wide   = RW'(plain_len_eff) - (strip ? RW'(2) : '0);
        res.found  = 1'b1;
      end else begin
        res.found = 1'b0;
      end
    end
    res.start_pos   = start_wide[START_W-1:0];
    res.addr_length = len_wide[LEN_W-1:0];
    res.overflow    = overflowed;
  end

  // scan state: an end marker or reset starts a fresh header
  always_ff @(posedge clk) begin
    if (rst || take_end) begin
      position             <= '0;
      escape_pending       <= 1'b0;
      in_angle             <= 1'b0;
      in_quote             <= 1'b0;
      comment_depth        <= '0;
      angle_start          <= '0;
      angle_start_valid    <= 1'b0;
      angle_len            <= '0;
      angle_len_valid      <= 1'b0;
      plain_start          <= '0;
      plain_start_valid    <= 1'b0;
      plain_len            <= '0;
      plain_len_valid      <= 1'b0;
      plain_first_is_quote <= 1'b0;
      plain_last_is_quote  <= 1'b0;
      prev_char_is_quote   <= 1'b0;
      overflowed           <= 1'b0;
    end else begin
      position             <= position_next;
      escape_pending       <= escape_pending_next;
      in_angle             <= in_angle_next;
      in_quote             <= in_quote_next;
      comment_depth        <= comment_depth_next;
      angle_start          <= angle_start_next;
      angle_start_valid    <= angle_start_valid_next;
      angle_len            <= angle_len_next;
      angle_len_valid      <= angle_len_valid_next;
      plain_start          <= plain_start_next;
      plain_start_valid    <= plain_start_valid_next;
      plain_len            <= plain_len_next;
      plain_len_valid      <= plain_len_valid_next;
      plain_first_is_quote <= plain_first_is_quote_next;
      plain_last_is_quote  <= plain_last_is_quote_next;
      prev_char_is_quote   <= prev_char_is_quote_next;
      overflowed           <= overflowed_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      out_word <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.found       = out_word.found;
  assign result.start_pos   = out_word.start_pos;
  assign result.addr_length = out_word.addr_length;
  assign result.overflow    = out_word.overflow;

endmodule
